// ===== src/hbfs_pkg.sv =====
// ----------------------------------------------------------------------------
// Header block frame splitter package
// Shared constants, the frame descriptor type and the header byte selector.
// ----------------------------------------------------------------------------
package hbfs_pkg;

  localparam logic [23:0] MFS_RESET         = 24'd16384;
  localparam logic [7:0]  TYPE_CONTINUATION = 8'd9;
  localparam logic [7:0]  FLAG_END_HEADERS  = 8'h04;
  localparam logic        OP_BEGIN          = 1'b0;
  localparam logic        OP_DATA           = 1'b1;
  localparam logic [3:0]  IDX_HDR_FIRST     = 4'd0;
  localparam logic [3:0]  IDX_HDR_LAST      = 4'd8;
  localparam logic [3:0]  IDX_PAYLOAD       = 4'd9;

  typedef struct packed {
    logic [23:0] len;
    logic [7:0]  ftype;
    logic [7:0]  flags;
    logic [31:0] stream;
    logic        has_hdr;
    logic        hdr_end;
    logic [7:0]  pay_byte;
    logic        has_pay;
    logic        pay_end;
    logic        err;
  } desc_t;

  function automatic logic [7:0] header_byte(input desc_t d, input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = d.len[23:16];
      4'd1:    b = d.len[15:8];
      4'd2:    b = d.len[7:0];
      4'd3:    b = d.ftype;
      4'd4:    b = d.flags;
      4'd5:    b = d.stream[31:24];
      4'd6:    b = d.stream[23:16];
      4'd7:    b = d.stream[15:8];
      4'd8:    b = d.stream[7:0];
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

// ===== src/hbfs_emitter.sv =====
// ----------------------------------------------------------------------------
// Header block frame splitter output emitter
// Walks one frame descriptor out as its header words, its payload word or both.
// ----------------------------------------------------------------------------
module hbfs_emitter
  import hbfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  desc_t       desc_i,
  input  logic        desc_valid_i,
  output logic        desc_take_o,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // out_byte, block_end, error_flag, zero fill
  output logic        out_tuser,   // is_header
  output logic        out_tlast
);

  desc_t      e_desc_r;
  logic       e_valid_r;
  logic [3:0] e_idx_r;
  logic       e_last;
  logic       is_hdr;
  logic [7:0] byte_sel;
  logic       end_sel;
  logic       err_sel;

  assign is_hdr = (e_idx_r != IDX_PAYLOAD);
  assign e_last = !is_hdr || ((e_idx_r == IDX_HDR_LAST) && !e_desc_r.has_pay);
  assign desc_take_o = !e_valid_r || (out_tready && e_last);

  always_comb begin
    if (is_hdr) begin
      byte_sel = header_byte(e_desc_r, e_idx_r);
      end_sel  = e_desc_r.hdr_end && (e_idx_r == IDX_HDR_LAST);
      err_sel  = 1'b0;
    end else begin
      byte_sel = e_desc_r.pay_byte;
      end_sel  = e_desc_r.pay_end;
      err_sel  = e_desc_r.err;
    end
  end

  assign out_tvalid = e_valid_r;
  assign out_tdata  = {6'd0, err_sel, end_sel, byte_sel};
  assign out_tuser  = is_hdr;
  assign out_tlast  = e_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
      e_idx_r   <= IDX_HDR_FIRST;
    end else if (desc_take_o) begin
      e_valid_r <= desc_valid_i;
      e_idx_r   <= desc_i.has_hdr ? IDX_HDR_FIRST : IDX_PAYLOAD;
    end else if (out_tready) begin
      e_idx_r <= e_idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (desc_take_o) begin
      e_desc_r <= desc_i;
    end
  end

endmodule

// ===== src/header_block_frame_splitter.sv =====
// ----------------------------------------------------------------------------
// Header block frame splitter
// Cuts an encoded header block into a first frame and CONTINUATION frames.
// ----------------------------------------------------------------------------
// A begin word carries the block length, stream id, first frame type and flags;
// data words carry the payload bytes. While out_tready is high, the block emits
// one output word per clock: a payload byte, preceded by a nine-word frame
// header when it opens a new frame; an empty block gets a header alone. An input
// word is taken every clock while each one yields at most one output word, so
// payload streams at full rate; a word that opens a frame yields ten output words,
// and the one descriptor buffer ahead of the output emitter sets when input stalls.
module header_block_frame_splitter
  import hbfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,    // data_byte, block_length, stream_number,
                                   // first_type, opening_flags
  input  logic        in_tuser,    // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // out_byte, block_end, error_flag, zero fill
  output logic        out_tuser,   // is_header
  output logic        out_tlast,   // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data     // max_frame_size
);

  logic [23:0] mfs_r;
  logic        open_r;
  logic [31:0] rem_r;
  logic [23:0] fleft_r;
  logic        first_done_r;
  logic [31:0] sv_stream_r;
  logic [7:0]  sv_type_r;
  logic [7:0]  sv_flags_r;
  logic        d_valid_r;
  desc_t       d_desc_r;

  logic        open_nxt;
  logic [31:0] rem_nxt;
  logic [23:0] fleft_nxt;
  logic        first_done_nxt;
  logic        d_valid_nxt;
  desc_t       d_desc_nxt;
  logic        produce;

  logic        d_take;
  logic        in_acc;
  logic [7:0]  in_byte;
  logic [31:0] in_len;
  logic [31:0] in_stream;
  logic [7:0]  in_type;
  logic [7:0]  in_flags;
  logic [23:0] mfs_eff;
  logic        rem_lt;
  logic        rem_le;
  logic [23:0] flen;
  logic [23:0] fl_cur;
  logic        need_hdr;

  assign in_byte   = in_tdata[7:0];
  assign in_len    = in_tdata[39:8];
  assign in_stream = in_tdata[71:40];
  assign in_type   = in_tdata[79:72];
  assign in_flags  = in_tdata[87:80];

  assign cfg_ready = 1'b1;
  assign in_tready = !d_valid_r || d_take;
  assign in_acc    = in_tvalid && in_tready;

  assign mfs_eff  = (mfs_r == 24'd0) ? 24'd1 : mfs_r;
  assign rem_lt   = rem_r < {8'd0, mfs_eff};
  assign rem_le   = rem_r <= {8'd0, mfs_eff};
  assign flen     = rem_lt ? rem_r[23:0] : mfs_eff;
  assign need_hdr = (fleft_r == 24'd0);
  assign fl_cur   = need_hdr ? flen : fleft_r;

  always_comb begin
    open_nxt       = open_r;
    rem_nxt        = rem_r;
    fleft_nxt      = fleft_r;
    first_done_nxt = first_done_r;
    produce        = 1'b0;
    d_desc_nxt     = '0;
    if (in_tuser == OP_BEGIN) begin
      first_done_nxt = 1'b0;
      fleft_nxt      = 24'd0;
      if (in_len == 32'd0) begin
        open_nxt           = 1'b0;
        rem_nxt            = 32'd0;
        produce            = 1'b1;
        d_desc_nxt.len     = 24'd0;
        d_desc_nxt.ftype   = in_type;
        d_desc_nxt.flags   = in_flags | FLAG_END_HEADERS;
        d_desc_nxt.stream  = in_stream;
        d_desc_nxt.has_hdr = 1'b1;
        d_desc_nxt.hdr_end = 1'b1;
      end else begin
        open_nxt = 1'b1;
        rem_nxt  = in_len;
      end
    end else if (!open_r) begin
      produce            = 1'b1;
      d_desc_nxt.has_pay = 1'b1;
      d_desc_nxt.err     = 1'b1;
    end else begin
      produce             = 1'b1;
      d_desc_nxt.len      = flen;
      d_desc_nxt.ftype    = first_done_r ? TYPE_CONTINUATION : sv_type_r;
      d_desc_nxt.flags    = (first_done_r ? 8'd0 : sv_flags_r)
                            | (rem_le ? FLAG_END_HEADERS : 8'd0);
      d_desc_nxt.stream   = sv_stream_r;
      d_desc_nxt.has_hdr  = need_hdr;
      d_desc_nxt.pay_byte = in_byte;
      d_desc_nxt.has_pay  = 1'b1;
      d_desc_nxt.pay_end  = (rem_r == 32'd1);
      if (need_hdr) begin
        first_done_nxt = 1'b1;
      end
      rem_nxt   = rem_r - 32'd1;
      fleft_nxt = fl_cur - 24'd1;
      if (rem_r == 32'd1) begin
        open_nxt  = 1'b0;
        fleft_nxt = 24'd0;
      end
    end
  end

  always_comb begin
    if (in_acc && produce) begin
      d_valid_nxt = 1'b1;
    end else if (d_take) begin
      d_valid_nxt = 1'b0;
    end else begin
      d_valid_nxt = d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mfs_r        <= MFS_RESET;
      open_r       <= 1'b0;
      rem_r        <= 32'd0;
      fleft_r      <= 24'd0;
      first_done_r <= 1'b0;
      sv_stream_r  <= 32'd0;
      sv_type_r    <= 8'd0;
      sv_flags_r   <= 8'd0;
      d_valid_r    <= 1'b0;
    end else begin
      d_valid_r <= d_valid_nxt;
      if (cfg_valid) begin
        mfs_r <= cfg_data;
      end
      if (in_acc) begin
        open_r       <= open_nxt;
        rem_r        <= rem_nxt;
        fleft_r      <= fleft_nxt;
        first_done_r <= first_done_nxt;
        if ((in_tuser == OP_BEGIN) && (in_len != 32'd0)) begin
          sv_stream_r <= in_stream;
          sv_type_r   <= in_type;
          sv_flags_r  <= in_flags;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && produce) begin
      d_desc_r <= d_desc_nxt;
    end
  end

  hbfs_emitter u_emitter (
    .clk          (clk),
    .rst_n        (rst_n),
    .desc_i       (d_desc_r),
    .desc_valid_i (d_valid_r),
    .desc_take_o  (d_take),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast)
  );

endmodule
